@@ design/frqs_pkg.sv @@
package frqs_pkg;

    // queue geometry
    localparam int QUEUE_DEPTH = 64;
    localparam int ID_BITS     = 8;

    // field widths, all but PTR_W seen at the ports
    localparam int CMD_W = 2;
    localparam int ID_W  = 8;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD   = 2'd0,
        CMD_YIELD = 2'd1,
        CMD_TERM  = 2'd2,
        CMD_NOP   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_TERM,
        S_REPLY
    } fqs_state_t;

    // circular slot index: head plus an offset below the depth, one compare and subtract
    function automatic logic [PTR_W-1:0] slot_of(
        input logic [PTR_W-1:0] head,
        input logic [PTR_W-1:0] offset
    );
        logic [PTR_W:0] sum;
        sum = {1'b0, head} + {1'b0, offset};
        if (sum >= (PTR_W+1)'(QUEUE_DEPTH))
        begin
            sum = sum - (PTR_W+1)'(QUEUE_DEPTH);
        end
        return sum[PTR_W-1:0];
    endfunction

endpackage

@@ design/fifo_ready_queue_scheduler_unit.sv @@
// FIFO ready queue of thread identifiers, one command per item and exactly one
// result item per command. add appends thread_id at the tail (status full and
// nothing stored when all QUEUE_DEPTH slots are taken); yield pops the head and
// returns it in dispatch_id with dispatch_valid set (status empty on an empty
// queue); terminate deletes every entry equal to thread_id, keeps the order of
// the rest and reports how many went in removed_count; command code 3 does
// nothing. queue_count always gives the fill level after the command. The
// queue lives in a single-port-write, single-port-read memory with a
// registered read, and one item is worked on at a time: in_stall is high from
// the cycle after an item is taken until its result has been moved to the
// output register. add, yield and the unused code take one execute step and
// then the reply step; terminate walks the queue through the memory read port
// one entry per cycle, compacting survivors in place through the write port,
// and goes to the reply step once the last entry read has been compared. A
// stalled output register that still holds the previous result holds the
// reply step until it is free. The output register keeps a finished result
// while the next item is already accepted and worked on.
module fifo_ready_queue_scheduler_unit
    import frqs_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,

    input  logic             in_valid,
    output logic             in_stall,
    input  logic [CMD_W-1:0] cmd,
    input  logic [ID_W-1:0]  thread_id,

    output logic             out_valid,
    input  logic             out_stall,
    output logic             dispatch_valid,
    output logic [ID_W-1:0]  dispatch_id,
    output logic [CNT_W-1:0] queue_count,
    output logic [CNT_W-1:0] removed_count,
    output logic [1:0]       status
);

    // sequencer
    fqs_state_t state_reg, state_next;

    // latched command
    cmd_t                 cmd_reg, cmd_next;
    logic [ID_BITS-1:0]   tid_reg, tid_next;

    // queue bookkeeping
    logic [PTR_W-1:0]     head_reg, head_next;
    logic [CNT_W-1:0]     count_reg, count_next;

    // terminate walk
    logic [CNT_W-1:0]     rd_idx_reg, rd_idx_next;
    logic [CNT_W-1:0]     kept_reg, kept_next;
    logic [CNT_W-1:0]     removed_reg, removed_next;
    logic                 pend_reg, pend_next;

    // finished result waiting for the output register
    logic                 res_dvalid_reg, res_dvalid_next;
    logic [ID_BITS-1:0]   res_id_reg, res_id_next;
    logic [CNT_W-1:0]     res_removed_reg, res_removed_next;
    status_t              res_status_reg, res_status_next;

    // output register
    logic                 out_valid_reg, out_valid_next;
    logic                 dvalid_reg, dvalid_next;
    logic [ID_W-1:0]      did_reg, did_next;
    logic [CNT_W-1:0]     qcount_reg, qcount_next;
    logic [CNT_W-1:0]     rcount_reg, rcount_next;
    status_t              status_reg, status_next;

    // queue memory
    logic [ID_BITS-1:0]   mem [QUEUE_DEPTH];
    logic                 mem_rd_en;
    logic [PTR_W-1:0]     mem_rd_addr;
    logic [ID_BITS-1:0]   rd_data_reg;
    logic                 mem_wr_en;
    logic [PTR_W-1:0]     mem_wr_addr;
    logic [ID_BITS-1:0]   mem_wr_data;

    logic                 accept;
    logic                 slot_free;
    logic                 walk_issue;

    assign accept     = in_valid && (state_reg == S_IDLE);
    assign slot_free  = !out_valid_reg || !out_stall;
    assign walk_issue = (rd_idx_reg < count_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (cmd_t'(cmd) == CMD_TERM)
                    begin
                        state_next = S_TERM;
                    end
                    else
                    begin
                        state_next = S_EXEC;
                    end
                end
            end
            S_EXEC:
            begin
                state_next = S_REPLY;
            end
            S_TERM:
            begin
                // walk done once nothing is issued and nothing is in flight
                if (!walk_issue && !pend_reg)
                begin
                    state_next = S_REPLY;
                end
            end
            S_REPLY:
            begin
                if (slot_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        in_stall         = (state_reg != S_IDLE);

        cmd_next         = cmd_reg;
        tid_next         = tid_reg;
        head_next        = head_reg;
        count_next       = count_reg;
        rd_idx_next      = rd_idx_reg;
        kept_next        = kept_reg;
        removed_next     = removed_reg;
        pend_next        = 1'b0;

        res_dvalid_next  = res_dvalid_reg;
        res_id_next      = res_id_reg;
        res_removed_next = res_removed_reg;
        res_status_next  = res_status_reg;

        out_valid_next   = out_valid_reg && out_stall;
        dvalid_next      = dvalid_reg;
        did_next         = did_reg;
        qcount_next      = qcount_reg;
        rcount_next      = rcount_reg;
        status_next      = status_reg;

        mem_rd_en        = 1'b0;
        mem_rd_addr      = head_reg;
        mem_wr_en        = 1'b0;
        mem_wr_addr      = head_reg;
        mem_wr_data      = tid_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd_next     = cmd_t'(cmd);
                    tid_next     = thread_id[ID_BITS-1:0];
                    rd_idx_next  = '0;
                    kept_next    = '0;
                    removed_next = '0;
                    // head fetched early so a yield finds it in the next cycle
                    mem_rd_en    = (cmd_t'(cmd) == CMD_YIELD);
                    mem_rd_addr  = head_reg;
                end
            end
            S_EXEC:
            begin
                res_dvalid_next  = 1'b0;
                res_id_next      = '0;
                res_removed_next = '0;
                res_status_next  = STAT_OK;
                case (cmd_reg)
                    CMD_ADD:
                    begin
                        if (count_reg == CNT_W'(QUEUE_DEPTH))
                        begin
                            res_status_next = STAT_FULL;
                        end
                        else
                        begin
                            mem_wr_en   = 1'b1;
                            mem_wr_addr = slot_of(head_reg, count_reg[PTR_W-1:0]);
                            mem_wr_data = tid_reg;
                            count_next  = count_reg + CNT_W'(1);
                        end
                    end
                    CMD_YIELD:
                    begin
                        if (count_reg == '0)
                        begin
                            res_status_next = STAT_EMPTY;
                        end
                        else
                        begin
                            res_dvalid_next = 1'b1;
                            res_id_next     = rd_data_reg;
                            head_next       = slot_of(head_reg, PTR_W'(1));
                            count_next      = count_reg - CNT_W'(1);
                        end
                    end
                    default:
                    begin
                        // unused code, nothing changes
                    end
                endcase
            end
            S_TERM:
            begin
                // read side: next entry of the walk
                if (walk_issue)
                begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = slot_of(head_reg, rd_idx_reg[PTR_W-1:0]);
                    rd_idx_next = rd_idx_reg + CNT_W'(1);
                    pend_next   = 1'b1;
                end
                // compare side: the entry read last cycle
                if (pend_reg)
                begin
                    if (rd_data_reg == tid_reg)
                    begin
                        removed_next = removed_reg + CNT_W'(1);
                    end
                    else
                    begin
                        // kept never runs ahead of the read index, so no unread slot is hit
                        mem_wr_en   = 1'b1;
                        mem_wr_addr = slot_of(head_reg, kept_reg[PTR_W-1:0]);
                        mem_wr_data = rd_data_reg;
                        kept_next   = kept_reg + CNT_W'(1);
                    end
                end
                if (!walk_issue && !pend_reg)
                begin
                    count_next       = kept_reg;
                    res_dvalid_next  = 1'b0;
                    res_id_next      = '0;
                    res_removed_next = removed_reg;
                    res_status_next  = STAT_OK;
                end
            end
            S_REPLY:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    dvalid_next    = res_dvalid_reg;
                    did_next       = ID_W'(res_id_reg);
                    qcount_next    = count_reg;
                    rcount_next    = res_removed_reg;
                    status_next    = res_status_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            rd_idx_reg    <= '0;
            kept_reg      <= '0;
            removed_reg   <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            rd_idx_reg    <= rd_idx_next;
            kept_reg      <= kept_next;
            removed_reg   <= removed_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg         <= cmd_next;
        tid_reg         <= tid_next;
        res_dvalid_reg  <= res_dvalid_next;
        res_id_reg      <= res_id_next;
        res_removed_reg <= res_removed_next;
        res_status_reg  <= res_status_next;
        dvalid_reg      <= dvalid_next;
        did_reg         <= did_next;
        qcount_reg      <= qcount_next;
        rcount_reg      <= rcount_next;
        status_reg      <= status_next;
    end

    // queue memory, registered read
    always_ff @(posedge clk)
    begin
        if (mem_wr_en)
        begin
            mem[mem_wr_addr] <= mem_wr_data;
        end
        if (mem_rd_en)
        begin
            rd_data_reg <= mem[mem_rd_addr];
        end
    end

    assign out_valid      = out_valid_reg;
    assign dispatch_valid = dvalid_reg;
    assign dispatch_id    = did_reg;
    assign queue_count    = qcount_reg;
    assign removed_count  = rcount_reg;
    assign status         = status_reg;

`ifndef SYNTHESIS
    // fill level never passes the depth
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("queue fill level above depth");

    // every entry of the walk is either kept, removed or still in flight
    a_walk_balance: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_TERM) |->
        ((CNT_W+1)'(kept_reg) + (CNT_W+1)'(removed_reg) + (CNT_W+1)'(pend_reg)
            == (CNT_W+1)'(rd_idx_reg)))
        else $error("terminate walk lost track of an entry");

    // a new result only comes out of the reply step
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_REPLY))
        else $error("result raised outside the reply step");

    // a dropped add always reports a full queue
    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (status_reg == STAT_FULL)) |->
        (qcount_reg == CNT_W'(QUEUE_DEPTH)))
        else $error("full status with queue not full");
`endif

endmodule

@@ sim/fifo_ready_queue_scheduler_unit_tb.sv @@
`timescale 1ns / 100ps

module fifo_ready_queue_scheduler_unit_tb;
    import frqs_pkg::*;

    localparam int RANDOM_ITEMS = 1450;
    localparam int IDLE_LIMIT   = 2000;   // cycles with no item moving on either side
    localparam int HOLD_CYCLES  = 400;    // long receiver hold-off, fills the block
    localparam int HOLD_AFTER   = 300;    // results seen before the hold-off starts
    localparam int DRAIN_CYCLES = 80;     // longer than a terminate over a full queue

    // one result item as seen on the output ports
    typedef struct packed {
        logic             dv;
        logic [ID_W-1:0]  did;
        logic [CNT_W-1:0] qcount;
        logic [CNT_W-1:0] rcount;
        status_t          st;
    } dispatch_result_t;

    // directed stimulus row, typed expectation only where obvious
    typedef struct {
        cmd_t             op;
        logic [ID_W-1:0]  tid;
        int               reps;
        bit               typed;
        dispatch_result_t want;
    } stim_row_t;

    logic             clk;
    logic             rst_n;
    logic             in_valid;
    logic             in_stall;
    logic [CMD_W-1:0] cmd;
    logic [ID_W-1:0]  thread_id;
    logic             out_valid;
    logic             out_stall;
    logic             dispatch_valid;
    logic [ID_W-1:0]  dispatch_id;
    logic [CNT_W-1:0] queue_count;
    logic [CNT_W-1:0] removed_count;
    logic [1:0]       status;

    // shadow of the ready queue, oldest entry first
    logic [ID_W-1:0]  ready_ids[$];
    // expected results in command order
    dispatch_result_t pending_results[$];

    int fail_count   = 0;
    int results_seen = 0;
    int burst_left   = 0;

    fifo_ready_queue_scheduler_unit dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .cmd            (cmd),
        .thread_id      (thread_id),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .dispatch_valid (dispatch_valid),
        .dispatch_id    (dispatch_id),
        .queue_count    (queue_count),
        .removed_count  (removed_count),
        .status         (status)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // apply one command to the shadow queue and return the result it gives
    function automatic dispatch_result_t schedule_command(input cmd_t op,
                                                          input logic [ID_W-1:0] tid);
        dispatch_result_t r;
        logic [ID_W-1:0]  key;
        logic [ID_W-1:0]  kept[$];
        r = '0;
        r.st = STAT_OK;
        key = tid & ID_W'((64'd1 << ID_BITS) - 1);
        case (op)
            CMD_ADD:
            begin
                if (ready_ids.size() >= QUEUE_DEPTH)
                begin
                    r.st = STAT_FULL;
                end
                else
                begin
                    ready_ids.push_back(key);
                end
            end
            CMD_YIELD:
            begin
                if (ready_ids.size() == 0)
                begin
                    r.st = STAT_EMPTY;
                end
                else
                begin
                    r.dv  = 1'b1;
                    r.did = ready_ids.pop_front();
                end
            end
            CMD_TERM:
            begin
                // drop every match, survivors keep their order
                foreach (ready_ids[k])
                begin
                    if (ready_ids[k] == key)
                    begin
                        r.rcount = r.rcount + 1'b1;
                    end
                    else
                    begin
                        kept.push_back(ready_ids[k]);
                    end
                end
                ready_ids = kept;
            end
            default:
            begin
            end
        endcase
        r.qcount = CNT_W'(ready_ids.size());
        return r;
    endfunction

    function automatic stim_row_t mk_row(input cmd_t op, input logic [ID_W-1:0] tid,
                                         input int reps, input bit typed,
                                         input logic dv, input logic [ID_W-1:0] did,
                                         input int qc, input int rc, input status_t st);
        stim_row_t row;
        row.op          = op;
        row.tid         = tid;
        row.reps        = reps;
        row.typed       = typed;
        row.want.dv     = dv;
        row.want.did    = did;
        row.want.qcount = CNT_W'(qc);
        row.want.rcount = CNT_W'(rc);
        row.want.st     = st;
        return row;
    endfunction

    task automatic check_result(input dispatch_result_t want, input dispatch_result_t got);
        if (got.dv !== want.dv)
        begin
            $error("dispatch_valid expected %0d actual %0d", want.dv, got.dv);
            fail_count++;
        end
        if (got.did !== want.did)
        begin
            $error("dispatch_id expected %0d actual %0d", want.did, got.did);
            fail_count++;
        end
        if (got.qcount !== want.qcount)
        begin
            $error("queue_count expected %0d actual %0d", want.qcount, got.qcount);
            fail_count++;
        end
        if (got.rcount !== want.rcount)
        begin
            $error("removed_count expected %0d actual %0d", want.rcount, got.rcount);
            fail_count++;
        end
        if (got.st !== want.st)
        begin
            $error("status expected %0d actual %0d", want.st, got.st);
            fail_count++;
        end
    endtask

    // offer one item, hold it until taken, then record its expected result
    task automatic send_item(input cmd_t op, input logic [ID_W-1:0] tid,
                             input bit typed, input dispatch_result_t want);
        dispatch_result_t predicted;
        cmd       <= op;
        thread_id <= tid;
        in_valid  <= 1'b1;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        predicted = schedule_command(op, tid);
        pending_results.push_back(typed ? want : predicted);
        // bursts of random length, random gaps between them
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(0, 12);
        end
    endtask

    // stimulus: directed table, then random command mix in phases
    initial
    begin
        stim_row_t        dir_rows[$];
        dispatch_result_t none;
        cmd_t             op;
        logic [ID_W-1:0]  tid;
        int               mix;
        int               pick;

        rst_n     = 1'b0;
        in_valid  = 1'b0;
        cmd       = CMD_NOP;
        thread_id = '0;
        none      = '0;

        dir_rows = '{
            // yield, terminate and idle code on an empty queue
            mk_row(CMD_YIELD, 8'h00, 1, 1, 0, 8'h00, 0, 0, STAT_EMPTY),
            mk_row(CMD_TERM,  8'h05, 1, 1, 0, 8'h00, 0, 0, STAT_OK),
            mk_row(CMD_NOP,   8'hff, 1, 1, 0, 8'h00, 0, 0, STAT_OK),
            // extreme ids go through in order
            mk_row(CMD_ADD,   8'h00, 1, 0, 0, 8'h00, 0, 0, STAT_OK),
            mk_row(CMD_ADD,   8'hff, 1, 0, 0, 8'h00, 0, 0, STAT_OK),
            mk_row(CMD_ADD,   8'haa, 1, 0, 0, 8'h00, 0, 0, STAT_OK),
            mk_row(CMD_ADD,   8'h55, 1, 0, 0, 8'h00, 0, 0, STAT_OK),
            mk_row(CMD_YIELD, 8'h00, 1, 1, 1, 8'h00, 3, 0, STAT_OK),
            mk_row(CMD_YIELD, 8'h00, 1, 1, 1, 8'hff, 2, 0, STAT_OK),
            // terminate with no match, then with two matches around a survivor
            mk_row(CMD_TERM,  8'h33, 1, 1, 0, 8'h00, 2, 0, STAT_OK),
            mk_row(CMD_ADD,   8'haa, 1, 0, 0, 8'h00, 0, 0, STAT_OK),
            mk_row(CMD_TERM,  8'haa, 1, 1, 0, 8'h00, 1, 2, STAT_OK),
            mk_row(CMD_YIELD, 8'h00, 1, 1, 1, 8'h55, 0, 0, STAT_OK),
            // fill up, add on a full queue, clear it with one terminate
            mk_row(CMD_ADD,   8'h07, QUEUE_DEPTH, 0, 0, 8'h00, 0, 0, STAT_OK),
            mk_row(CMD_ADD,   8'h09, 1, 1, 0, 8'h00, QUEUE_DEPTH, 0, STAT_FULL),
            mk_row(CMD_TERM,  8'h07, 1, 1, 0, 8'h00, 0, QUEUE_DEPTH, STAT_OK),
            // move the head around, then compact across the wrap point
            mk_row(CMD_ADD,   8'h11, 40, 0, 0, 8'h00, 0, 0, STAT_OK),
            mk_row(CMD_YIELD, 8'h00, 30, 0, 0, 8'h00, 0, 0, STAT_OK),
            mk_row(CMD_ADD,   8'h22, 50, 0, 0, 8'h00, 0, 0, STAT_OK),
            mk_row(CMD_NOP,   8'h00, 1, 0, 0, 8'h00, 0, 0, STAT_OK),
            mk_row(CMD_TERM,  8'h11, 1, 0, 0, 8'h00, 0, 0, STAT_OK),
            mk_row(CMD_YIELD, 8'h00, 50, 0, 0, 8'h00, 0, 0, STAT_OK),
            mk_row(CMD_YIELD, 8'h00, 1, 1, 0, 8'h00, 0, 0, STAT_EMPTY)
        };

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[r])
        begin
            for (int k = 0; k < dir_rows[r].reps; k++)
            begin
                send_item(dir_rows[r].op, dir_rows[r].tid, dir_rows[r].typed,
                          dir_rows[r].want);
            end
        end

        // phases: fill heavy, drain heavy, balanced
        mix = 0;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 120 == 0)
            begin
                mix = $urandom_range(0, 2);
            end
            pick = $urandom_range(0, 99);
            case (mix)
                0:       op = (pick < 75) ? CMD_ADD : (pick < 85) ? CMD_YIELD
                            : (pick < 95) ? CMD_TERM : CMD_NOP;
                1:       op = (pick < 15) ? CMD_ADD : (pick < 85) ? CMD_YIELD
                            : (pick < 95) ? CMD_TERM : CMD_NOP;
                default: op = (pick < 45) ? CMD_ADD : (pick < 85) ? CMD_YIELD
                            : (pick < 95) ? CMD_TERM : CMD_NOP;
            endcase
            // small id pool half the time so terminate finds repeats
            if ($urandom_range(0, 1) == 1)
            begin
                tid = ID_W'($urandom_range(0, 255));
            end
            else
            begin
                tid = ID_W'($urandom_range(0, 7) * 37);
            end
            if (op == CMD_TERM && ready_ids.size() > 0 && $urandom_range(0, 9) < 7)
            begin
                tid = ready_ids[$urandom_range(0, ready_ids.size() - 1)];
            end
            send_item(op, tid, 1'b0, none);
        end

        in_valid <= 1'b0;
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // receiver: check each accepted result, stall on its own pattern
    initial
    begin
        dispatch_result_t got;
        int               stall_mode;
        int               mode_left;
        int               hold_left;
        int               phase_ctr;
        bit               hold_done;

        out_stall  = 1'b0;
        stall_mode = 0;
        mode_left  = 0;
        hold_left  = 0;
        phase_ctr  = 0;
        hold_done  = 1'b0;

        forever
        begin
            @(posedge clk);
            phase_ctr++;
            if (out_valid && !out_stall)
            begin
                got.dv     = dispatch_valid;
                got.did    = dispatch_id;
                got.qcount = queue_count;
                got.rcount = removed_count;
                got.st     = status_t'(status);
                if (pending_results.size() == 0)
                begin
                    $error("result item with no command pending");
                    fail_count++;
                end
                else
                begin
                    check_result(pending_results.pop_front(), got);
                end
                results_seen++;
                if (!hold_done && results_seen >= HOLD_AFTER)
                begin
                    hold_done = 1'b1;
                    hold_left = HOLD_CYCLES;
                end
            end
            if (hold_left > 0)
            begin
                // sender keeps offering, block must back up and stall its input
                hold_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    stall_mode = $urandom_range(0, 3);
                    mode_left  = $urandom_range(20, 150);
                end
                mode_left--;
                case (stall_mode)
                    0:       out_stall <= 1'b0;
                    1:       out_stall <= ($urandom_range(0, 3) == 0);
                    2:       out_stall <= ($urandom_range(0, 9) < 7);
                    default: out_stall <= (phase_ctr % 8 < 3);
                endcase
            end
        end
    end

    // watchdog on cycles where no item moves
    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

endmodule

@@ filelist.f @@
design/frqs_pkg.sv
design/fifo_ready_queue_scheduler_unit.sv
sim/fifo_ready_queue_scheduler_unit_tb.sv
